/* hw/rtl/dltcc_pkg.sv */
package dltcc_pkg;

    localparam int DEF_MAX_NODES = 16;
    localparam int DEF_MAX_LINKS = 64;
    localparam int DEF_ID_BITS   = 16;

    localparam logic [3:0] SAT_LEVEL = 4'd15;

    typedef enum logic [2:0] {
        REQ_ADD_NODE    = 3'd0,
        REQ_ADD_LINK    = 3'd1,
        REQ_REMOVE_LINK = 3'd2,
        REQ_REMOVE_NODE = 3'd3,
        REQ_ARRANGE     = 3'd4,
        REQ_CLEAR       = 3'd5
    } req_t;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_REJECT = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DUP,
        S_WALK,
        S_LINK_END,
        S_RMLINK,
        S_RMNODE,
        S_LEVEL,
        S_EMIT
    } state_t;

endpackage

/* hw/rtl/dag_link_table_cycle_check.sv */
// Dependency graph keeper with a node table in flip-flops and a link table in a synchronous
// memory with one read port. Add node, remove link, remove node and clear each return one item;
// a remove scans the link table once. Add link scans the link table once for duplicates and a
// free slot, then once per pass of the reachability walk until a pass adds no node. Arrange
// makes one pass over the link table per node and then returns one item per node, in table
// order, producing the next item only once the previous one has been taken. A new item is
// taken only after the previous result has left.
module dag_link_table_cycle_check #(
    parameter int MAX_NODES = dltcc_pkg::DEF_MAX_NODES,
    parameter int MAX_LINKS = dltcc_pkg::DEF_MAX_LINKS,
    parameter int ID_BITS   = dltcc_pkg::DEF_ID_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  req_type,
    input  logic [17:0] pin_a,
    input  logic [17:0] pin_b,
    input  logic [15:0] node_sel,
    input  logic [15:0] link_sel,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [15:0] node_out,
    output logic [15:0] link_out,
    output logic [3:0]  level,
    output logic [3:0]  row,
    output logic        last
);
    import dltcc_pkg::*;

    localparam int NW = $clog2(MAX_NODES);
    localparam int LW = $clog2(MAX_LINKS);
    localparam int CW = (ID_BITS > 17) ? ID_BITS : 17;
    localparam int DW = 3 * ID_BITS;

    typedef logic [ID_BITS-1:0] node_arr_t [MAX_NODES];
    typedef logic [3:0] lvl_arr_t [MAX_NODES];
    typedef logic [3:0] row_arr_t [16];

    function automatic logic [NW:0] find_slot(input logic [CW-1:0] id, input node_arr_t tbl,
                                              input logic [NW:0] cnt);
        logic [NW:0] res;
        res = '0;
        for (int i = 0; i < MAX_NODES; i++)
        begin
            if ((NW+1)'(i) < cnt && CW'(tbl[i]) == id)
            begin
                res = {1'b1, NW'(i)};
            end
        end
        return res;
    endfunction

    state_t state_reg, state_next;
    node_arr_t node_reg, node_next;
    logic [NW:0] count_reg, count_next;
    logic [ID_BITS:0] next_node_reg, next_node_next;
    logic [ID_BITS:0] next_link_reg, next_link_next;
    logic [MAX_LINKS-1:0] lvalid_reg, lvalid_next;
    logic [MAX_NODES-1:0] vis_reg, vis_next;
    lvl_arr_t lvl_reg, lvl_next;
    row_arr_t row_reg, row_next;
    logic [NW-1:0] src_slot_reg, src_slot_next, tgt_slot_reg, tgt_slot_next;
    logic [ID_BITS-1:0] src_id_reg, src_id_next, tgt_id_reg, tgt_id_next;
    logic [15:0] sel_reg, sel_next;
    logic [LW:0] cnt_reg, cnt_next;
    logic [LW:0] free_reg, free_next;
    logic rd_act_reg, rd_act_next;
    logic [LW-1:0] rd_idx_reg, rd_idx_next;
    logic [NW:0] pass_reg, pass_next;
    logic flag_reg, flag_next;
    logic out_valid_reg, out_valid_next;
    logic [1:0] status_reg, status_next;
    logic [15:0] node_out_reg, node_out_next, link_out_reg, link_out_next;
    logic [3:0] level_reg, level_next, row_out_reg, row_out_next;
    logic last_reg, last_next;

    logic [DW-1:0] link_mem [MAX_LINKS];
    logic [DW-1:0] rd_data_reg;
    logic wr_en;
    logic [LW-1:0] wr_addr;
    logic [DW-1:0] wr_data;
    logic rd_en;

    logic [ID_BITS-1:0] e_id, e_src, e_tgt;
    logic e_valid, scan_done;
    logic [NW:0] s_look, t_look;
    logic [NW:0] a_look, b_look, n_look;
    logic [CW-1:0] a_id, b_id;

    assign in_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign status = status_reg;
    assign node_out = node_out_reg;
    assign link_out = link_out_reg;
    assign level = level_reg;
    assign row = row_out_reg;
    assign last = last_reg;

    assign e_id = rd_data_reg[DW-1 -: ID_BITS];
    assign e_src = rd_data_reg[2*ID_BITS-1 -: ID_BITS];
    assign e_tgt = rd_data_reg[ID_BITS-1:0];
    assign e_valid = rd_act_reg && lvalid_reg[rd_idx_reg];
    assign scan_done = rd_act_reg && (rd_idx_reg == LW'(MAX_LINKS - 1));
    assign s_look = find_slot(CW'(e_src), node_reg, count_reg);
    assign t_look = find_slot(CW'(e_tgt), node_reg, count_reg);
    assign a_id = pin_a[0] ? CW'(pin_a[17:1]) : CW'(pin_a[17:1] - 17'd1);
    assign b_id = pin_b[0] ? CW'(pin_b[17:1]) : CW'(pin_b[17:1] - 17'd1);
    assign a_look = find_slot(a_id, node_reg, count_reg);
    assign b_look = find_slot(b_id, node_reg, count_reg);
    assign n_look = find_slot(CW'(sel_reg), node_reg, count_reg);
    assign rd_en = (state_reg == S_DUP || state_reg == S_WALK || state_reg == S_RMLINK
                    || state_reg == S_RMNODE || state_reg == S_LEVEL)
                   && (cnt_reg < (LW+1)'(MAX_LINKS));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            link_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= link_mem[cnt_reg[LW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            next_node_reg <= (ID_BITS+1)'(1);
            next_link_reg <= (ID_BITS+1)'(1);
            lvalid_reg <= '0;
            rd_act_reg <= 1'b0;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            next_node_reg <= next_node_next;
            next_link_reg <= next_link_next;
            lvalid_reg <= lvalid_next;
            rd_act_reg <= rd_act_next;
            cnt_reg <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg <= node_next;
        vis_reg <= vis_next;
        lvl_reg <= lvl_next;
        row_reg <= row_next;
        src_slot_reg <= src_slot_next;
        tgt_slot_reg <= tgt_slot_next;
        src_id_reg <= src_id_next;
        tgt_id_reg <= tgt_id_next;
        sel_reg <= sel_next;
        free_reg <= free_next;
        rd_idx_reg <= rd_idx_next;
        pass_reg <= pass_next;
        flag_reg <= flag_next;
        status_reg <= status_next;
        node_out_reg <= node_out_next;
        link_out_reg <= link_out_next;
        level_reg <= level_next;
        row_out_reg <= row_out_next;
        last_reg <= last_next;
    end

    always_comb
    begin
        logic [NW-1:0] sa, sb;
        logic [3:0] cand, lv;
        logic ch;
        state_next = state_reg;
        node_next = node_reg;
        count_next = count_reg;
        next_node_next = next_node_reg;
        next_link_next = next_link_reg;
        lvalid_next = lvalid_reg;
        vis_next = vis_reg;
        lvl_next = lvl_reg;
        row_next = row_reg;
        src_slot_next = src_slot_reg;
        tgt_slot_next = tgt_slot_reg;
        src_id_next = src_id_reg;
        tgt_id_next = tgt_id_reg;
        sel_next = sel_reg;
        free_next = free_reg;
        pass_next = pass_reg;
        flag_next = flag_reg;
        status_next = status_reg;
        node_out_next = node_out_reg;
        link_out_next = link_out_reg;
        level_next = level_reg;
        row_out_next = row_out_reg;
        last_next = last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        rd_act_next = rd_en;
        rd_idx_next = cnt_reg[LW-1:0];
        cnt_next = rd_en ? cnt_reg + 1'b1 : cnt_reg;
        wr_en = 1'b0;
        wr_addr = free_reg[LW-1:0];
        wr_data = {ID_BITS'(next_link_reg), src_id_reg, tgt_id_reg};
        sa = a_look[NW-1:0];
        sb = b_look[NW-1:0];
        cand = '0;
        lv = '0;
        ch = 1'b0;

        if (state_reg == S_IDLE && in_valid && in_ready)
        begin
            status_next = ST_DONE;
            node_out_next = '0;
            link_out_next = '0;
            level_next = '0;
            row_out_next = '0;
            last_next = 1'b1;
            sel_next = (req_type == REQ_REMOVE_LINK) ? link_sel : node_sel;
            cnt_next = '0;
            case (req_type)
                REQ_ADD_NODE:
                begin
                    out_valid_next = 1'b1;
                    if (count_reg >= (NW+1)'(MAX_NODES) || next_node_reg[ID_BITS])
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        node_next[count_reg[NW-1:0]] = ID_BITS'(next_node_reg);
                        count_next = count_reg + 1'b1;
                        node_out_next = 16'(next_node_reg[ID_BITS-1:0]);
                        next_node_next = next_node_reg + 1'b1;
                    end
                end
                REQ_ADD_LINK:
                begin
                    if (pin_a == '0 || pin_b == '0 || !a_look[NW] || !b_look[NW]
                        || pin_a[0] == pin_b[0] || sa == sb)
                    begin
                        out_valid_next = 1'b1;
                        status_next = ST_REJECT;
                    end
                    else
                    begin
                        src_slot_next = pin_a[0] ? sb : sa;
                        tgt_slot_next = pin_a[0] ? sa : sb;
                        src_id_next = pin_a[0] ? node_reg[sb] : node_reg[sa];
                        tgt_id_next = pin_a[0] ? node_reg[sa] : node_reg[sb];
                        free_next = (LW+1)'(MAX_LINKS);
                        flag_next = 1'b0;
                        state_next = S_DUP;
                    end
                end
                REQ_REMOVE_LINK: state_next = S_RMLINK;
                REQ_REMOVE_NODE: state_next = S_RMNODE;
                REQ_ARRANGE:
                begin
                    if (count_reg == '0)
                    begin
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        for (int i = 0; i < MAX_NODES; i++)
                        begin
                            lvl_next[i] = '0;
                        end
                        for (int i = 0; i < 16; i++)
                        begin
                            row_next[i] = '0;
                        end
                        pass_next = '0;
                        state_next = S_LEVEL;
                    end
                end
                REQ_CLEAR:
                begin
                    out_valid_next = 1'b1;
                    count_next = '0;
                    next_node_next = (ID_BITS+1)'(1);
                    next_link_next = (ID_BITS+1)'(1);
                    lvalid_next = '0;
                end
                default: ;
            endcase
        end
        else
        begin
            case (state_reg)
                S_DUP:
                begin
                    if (rd_act_reg && !e_valid && free_reg == (LW+1)'(MAX_LINKS))
                    begin
                        free_next = (LW+1)'(rd_idx_reg);
                    end
                    ch = flag_reg || (e_valid && e_src == src_id_reg && e_tgt == tgt_id_reg);
                    flag_next = ch;
                    if (scan_done)
                    begin
                        cnt_next = '0;
                        if (ch)
                        begin
                            out_valid_next = 1'b1;
                            status_next = ST_REJECT;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            vis_next = '0;
                            vis_next[tgt_slot_reg] = 1'b1;
                            flag_next = 1'b0;
                            state_next = S_WALK;
                        end
                    end
                end
                S_WALK:
                begin
                    ch = flag_reg;
                    if (e_valid && s_look[NW] && t_look[NW] && vis_reg[s_look[NW-1:0]]
                        && !vis_reg[t_look[NW-1:0]])
                    begin
                        vis_next[t_look[NW-1:0]] = 1'b1;
                        ch = 1'b1;
                    end
                    flag_next = ch;
                    if (scan_done)
                    begin
                        cnt_next = '0;
                        flag_next = 1'b0;
                        if (!ch)
                        begin
                            state_next = S_LINK_END;
                        end
                    end
                end
                S_LINK_END:
                begin
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                    if (vis_reg[src_slot_reg])
                    begin
                        status_next = ST_REJECT;
                    end
                    else if (free_reg == (LW+1)'(MAX_LINKS) || next_link_reg[ID_BITS])
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        wr_en = 1'b1;
                        lvalid_next[free_reg[LW-1:0]] = 1'b1;
                        link_out_next = 16'(next_link_reg[ID_BITS-1:0]);
                        next_link_next = next_link_reg + 1'b1;
                    end
                end
                S_RMLINK:
                begin
                    if (e_valid && CW'(e_id) == CW'(sel_reg))
                    begin
                        lvalid_next[rd_idx_reg] = 1'b0;
                    end
                    if (scan_done)
                    begin
                        cnt_next = '0;
                        out_valid_next = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                S_RMNODE:
                begin
                    if (e_valid && (CW'(e_src) == CW'(sel_reg) || CW'(e_tgt) == CW'(sel_reg)))
                    begin
                        lvalid_next[rd_idx_reg] = 1'b0;
                    end
                    if (scan_done)
                    begin
                        cnt_next = '0;
                        out_valid_next = 1'b1;
                        state_next = S_IDLE;
                        if (n_look[NW])
                        begin
                            for (int i = 0; i < MAX_NODES - 1; i++)
                            begin
                                if (NW'(i) >= n_look[NW-1:0])
                                begin
                                    node_next[i] = node_reg[i+1];
                                end
                            end
                            count_next = count_reg - 1'b1;
                        end
                    end
                end
                S_LEVEL:
                begin
                    if (e_valid && s_look[NW] && t_look[NW])
                    begin
                        cand = (lvl_reg[s_look[NW-1:0]] == SAT_LEVEL) ? SAT_LEVEL
                               : lvl_reg[s_look[NW-1:0]] + 4'd1;
                        if (cand > lvl_reg[t_look[NW-1:0]])
                        begin
                            lvl_next[t_look[NW-1:0]] = cand;
                        end
                    end
                    if (scan_done)
                    begin
                        cnt_next = '0;
                        if (pass_reg + 1'b1 == count_reg)
                        begin
                            pass_next = '0;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            pass_next = pass_reg + 1'b1;
                        end
                    end
                end
                S_EMIT:
                begin
                    if (!out_valid_reg)
                    begin
                        lv = lvl_reg[pass_reg[NW-1:0]];
                        out_valid_next = 1'b1;
                        status_next = ST_DONE;
                        node_out_next = 16'(node_reg[pass_reg[NW-1:0]]);
                        link_out_next = '0;
                        level_next = lv;
                        row_out_next = row_reg[lv];
                        if (row_reg[lv] < SAT_LEVEL)
                        begin
                            row_next[lv] = row_reg[lv] + 4'd1;
                        end
                        last_next = (pass_reg + 1'b1 == count_reg);
                        pass_next = pass_reg + 1'b1;
                        if (pass_reg + 1'b1 == count_reg)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
                default: state_next = S_IDLE;
            endcase
        end
    end

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid_reg)
        else $error("input taken while a result waits");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (NW+1)'(MAX_NODES))
        else $error("node count beyond table size");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (status_reg == ST_DONE || status_reg == ST_REJECT
                           || status_reg == ST_FULL))
        else $error("bad status code");

    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> !in_ready)
        else $error("input accepted during arrange output");

endmodule

/* test/tb_top.sv */
module tb_top;
    import dltcc_pkg::*;

    localparam int NODE_CAP = 16;
    localparam int LINK_CAP = 64;
    localparam int ID_MAX = 65535;
    localparam int STALL_LIMIT = 200000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  req_type;
    logic [17:0] pin_a;
    logic [17:0] pin_b;
    logic [15:0] node_sel;
    logic [15:0] link_sel;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [15:0] node_out;
    logic [15:0] link_out;
    logic [3:0]  level;
    logic [3:0]  row;
    logic        last;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] node_out;
        logic [15:0] link_out;
        logic [3:0]  level;
        logic [3:0]  row;
        logic        last;
    } graph_result_t;

    typedef struct {
        logic [2:0]    req;
        logic [17:0]   pa;
        logic [17:0]   pb;
        logic [15:0]   nsel;
        logic [15:0]   lsel;
        bit            typed;
        graph_result_t want;
    } request_row_t;

    dag_link_table_cycle_check u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .pin_a(pin_a), .pin_b(pin_b),
        .node_sel(node_sel), .link_sel(link_sel),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .node_out(node_out), .link_out(link_out),
        .level(level), .row(row), .last(last)
    );

    // Shadow graph state.
    int          g_nodes[NODE_CAP];
    int          g_count;
    bit          l_valid[LINK_CAP];
    int          l_id[LINK_CAP];
    int          l_src[LINK_CAP];
    int          l_tgt[LINK_CAP];
    int          next_node;
    int          next_link;

    graph_result_t pending_results[$];
    request_row_t  plan[$];
    int          errors;
    int          idle_cycles;
    bit          calm;
    bit          hold_off;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic report(input string what, input graph_result_t got, input graph_result_t exp);
        $display("mismatch %s: got %h expected %h", what, got, exp);
        errors++;
    endtask

    function automatic void queue_result(input graph_result_t r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    function automatic void plan_add(input request_row_t r);
        plan.insert(plan.size(), r);
    endfunction

    function automatic graph_result_t mk(input int st, input int nd, input int ln,
                                         input int lv, input int rw, input int la);
        graph_result_t r;
        r.status = st[1:0];
        r.node_out = nd[15:0];
        r.link_out = ln[15:0];
        r.level = lv[3:0];
        r.row = rw[3:0];
        r.last = la[0];
        return r;
    endfunction

    function automatic int slot_of(input int id);
        for (int i = 0; i < g_count; i++)
            if (g_nodes[i] == id)
                return i;
        return -1;
    endfunction

    function automatic void clear_graph();
        g_count = 0;
        for (int j = 0; j < LINK_CAP; j++)
            l_valid[j] = 0;
        next_node = 1;
        next_link = 1;
    endfunction

    function automatic bit reaches(input int start, input int goal);
        bit seen[NODE_CAP];
        bit changed;
        int s;
        int t;
        for (int i = 0; i < NODE_CAP; i++)
            seen[i] = 0;
        seen[start] = 1;
        changed = 1;
        while (changed) begin
            changed = 0;
            for (int j = 0; j < LINK_CAP; j++) begin
                if (l_valid[j]) begin
                    s = slot_of(l_src[j]);
                    t = slot_of(l_tgt[j]);
                    if (s >= 0 && t >= 0 && seen[s] && !seen[t]) begin
                        seen[t] = 1;
                        changed = 1;
                    end
                end
            end
        end
        return seen[goal];
    endfunction

    function automatic int pin_slot(input int pin, output bit is_out);
        is_out = 0;
        if (pin == 0)
            return -1;
        if (pin % 2 == 1)
            return slot_of((pin - 1) / 2);
        is_out = 1;
        return slot_of((pin - 2) / 2);
    endfunction

    function automatic int link_status(input int pa, input int pb, output int lid);
        bit oa;
        bit ob;
        int sa;
        int sb;
        int src;
        int tgt;
        int free_at;
        lid = 0;
        sa = pin_slot(pa, oa);
        sb = pin_slot(pb, ob);
        if (sa < 0 || sb < 0 || oa == ob)
            return ST_REJECT;
        src = oa ? sa : sb;
        tgt = oa ? sb : sa;
        if (src == tgt)
            return ST_REJECT;
        free_at = -1;
        for (int j = 0; j < LINK_CAP; j++) begin
            if (!l_valid[j]) begin
                if (free_at < 0)
                    free_at = j;
            end else if (l_src[j] == g_nodes[src] && l_tgt[j] == g_nodes[tgt]) begin
                return ST_REJECT;
            end
        end
        if (reaches(tgt, src))
            return ST_REJECT;
        if (free_at < 0 || next_link > ID_MAX)
            return ST_FULL;
        l_valid[free_at] = 1;
        l_id[free_at] = next_link;
        l_src[free_at] = g_nodes[src];
        l_tgt[free_at] = g_nodes[tgt];
        lid = next_link;
        next_link++;
        return ST_DONE;
    endfunction

    function automatic void predict_graph(input request_row_t r);
        int lid;
        int st;
        int s;
        int t;
        int cand;
        int lv;
        int lvl[NODE_CAP];
        int rows[16];
        case (r.req)
            REQ_ADD_NODE: begin
                if (g_count >= NODE_CAP || next_node > ID_MAX) begin
                    queue_result(mk(ST_FULL, 0, 0, 0, 0, 1));
                end else begin
                    g_nodes[g_count] = next_node;
                    g_count++;
                    queue_result(mk(ST_DONE, next_node, 0, 0, 0, 1));
                    next_node++;
                end
            end
            REQ_ADD_LINK: begin
                st = link_status(r.pa, r.pb, lid);
                queue_result(mk(st, 0, lid, 0, 0, 1));
            end
            REQ_REMOVE_LINK: begin
                for (int j = 0; j < LINK_CAP; j++)
                    if (l_valid[j] && l_id[j] == r.lsel)
                        l_valid[j] = 0;
                queue_result(mk(ST_DONE, 0, 0, 0, 0, 1));
            end
            REQ_REMOVE_NODE: begin
                for (int j = 0; j < LINK_CAP; j++)
                    if (l_valid[j] && (l_src[j] == r.nsel || l_tgt[j] == r.nsel))
                        l_valid[j] = 0;
                s = slot_of(r.nsel);
                if (s >= 0) begin
                    for (int i = s; i + 1 < g_count; i++)
                        g_nodes[i] = g_nodes[i + 1];
                    g_count--;
                end
                queue_result(mk(ST_DONE, 0, 0, 0, 0, 1));
            end
            REQ_ARRANGE: begin
                if (g_count == 0) begin
                    queue_result(mk(ST_DONE, 0, 0, 0, 0, 1));
                end else begin
                    for (int i = 0; i < NODE_CAP; i++)
                        lvl[i] = 0;
                    for (int i = 0; i < 16; i++)
                        rows[i] = 0;
                    for (int p = 0; p < g_count; p++) begin
                        for (int j = 0; j < LINK_CAP; j++) begin
                            if (l_valid[j]) begin
                                s = slot_of(l_src[j]);
                                t = slot_of(l_tgt[j]);
                                if (s >= 0 && t >= 0) begin
                                    cand = lvl[s] + 1;
                                    if (cand > 15)
                                        cand = 15;
                                    if (cand > lvl[t])
                                        lvl[t] = cand;
                                end
                            end
                        end
                    end
                    for (int i = 0; i < g_count; i++) begin
                        lv = lvl[i];
                        queue_result(mk(ST_DONE, g_nodes[i], 0, lv, rows[lv],
                                        i + 1 == g_count));
                        if (rows[lv] < 15)
                            rows[lv]++;
                    end
                end
            end
            REQ_CLEAR: begin
                clear_graph();
                queue_result(mk(ST_DONE, 0, 0, 0, 0, 1));
            end
            default: begin
            end
        endcase
    endfunction

    function automatic request_row_t req_row(input int rq, input int pa, input int pb,
                                             input int ns, input int ls);
        request_row_t r;
        r.req = rq[2:0];
        r.pa = pa[17:0];
        r.pb = pb[17:0];
        r.nsel = ns[15:0];
        r.lsel = ls[15:0];
        r.typed = 0;
        r.want = '0;
        return r;
    endfunction

    function automatic request_row_t typed_row(input request_row_t r, input graph_result_t w);
        request_row_t x;
        x = r;
        x.typed = 1;
        x.want = w;
        return x;
    endfunction

    // Pin of node id: output when is_out is set.
    function automatic int pin_of(input int id, input int is_out);
        return (is_out != 0) ? 2 * id + 2 : 2 * id + 1;
    endfunction

    function automatic request_row_t random_request();
        int pick;
        int a;
        int b;
        pick = $urandom_range(0, 99);
        if (pick < 18)
            return req_row(REQ_ADD_NODE, $urandom, $urandom, $urandom, $urandom);
        if (pick < 60) begin
            a = (g_count > 0) ? g_nodes[$urandom_range(0, g_count - 1)] : 1;
            b = (g_count > 0) ? g_nodes[$urandom_range(0, g_count - 1)] : 2;
            if ($urandom_range(0, 9) == 0)
                return req_row(REQ_ADD_LINK, $urandom_range(0, 262143),
                               $urandom_range(0, 262143), $urandom, $urandom);
            if ($urandom_range(0, 1))
                return req_row(REQ_ADD_LINK, pin_of(a, 1), pin_of(b, 0), $urandom, $urandom);
            return req_row(REQ_ADD_LINK, pin_of(b, 0), pin_of(a, 1), $urandom, $urandom);
        end
        if (pick < 72)
            return req_row(REQ_REMOVE_LINK, $urandom, $urandom, $urandom,
                           ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, next_link));
        if (pick < 80) begin
            a = (g_count > 0 && $urandom_range(0, 3) != 0) ?
                g_nodes[$urandom_range(0, g_count - 1)] : $urandom_range(0, 65535);
            return req_row(REQ_REMOVE_NODE, $urandom, $urandom, a, $urandom);
        end
        if (pick < 92)
            return req_row(REQ_ARRANGE, $urandom, $urandom, $urandom, $urandom);
        if (pick < 95)
            return req_row(REQ_CLEAR, $urandom, $urandom, $urandom, $urandom);
        return req_row($urandom_range(6, 7), $urandom, $urandom, $urandom, $urandom);
    endfunction

    task automatic offer_item(input request_row_t r);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 7);
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= r.req;
        pin_a <= r.pa;
        pin_b <= r.pb;
        node_sel <= r.nsel;
        link_sel <= r.lsel;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (r.typed && r.want != mk(0, 0, 0, 0, 0, 0)) begin
            queue_result(r.want);
            predict_graph(r);
            pending_results.delete(pending_results.size() - 1);
        end else begin
            predict_graph(r);
        end
    endtask

    // Receiver side.
    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off) begin
                out_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                out_ready <= 1'b0;
                gap = $urandom_range(1, 7);
                repeat (gap) @(posedge clk);
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Checker.
    always @(posedge clk)
    begin
        graph_result_t got;
        graph_result_t exp;
        if (rst_n && out_valid && out_ready) begin
            got = {status, node_out, link_out, level, row, last};
            if (pending_results.size() == 0) begin
                report("unexpected item", got, '0);
            end else begin
                exp = pending_results.pop_front();
                if (got.status != exp.status) report("status", got, exp);
                if (got.node_out != exp.node_out) report("node_out", got, exp);
                if (got.link_out != exp.link_out) report("link_out", got, exp);
                if (got.level != exp.level) report("level", got, exp);
                if (got.row != exp.row) report("row", got, exp);
                if (got.last != exp.last) report("last", got, exp);
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n || hold_off)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial
    begin
        int n;
        calm = 0;
        hold_off = 0;
        clear_graph();
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = '0;
        pin_a = '0;
        pin_b = '0;
        node_sel = '0;
        link_sel = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        plan_add(typed_row(req_row(REQ_ARRANGE, 0, 0, 0, 0), mk(ST_DONE, 0, 0, 0, 0, 1)));
        plan_add(typed_row(req_row(REQ_ADD_LINK, 0, 0, 0, 0), mk(ST_REJECT, 0, 0, 0, 0, 1)));
        plan_add(typed_row(req_row(REQ_ADD_NODE, 0, 0, 0, 0), mk(ST_DONE, 1, 0, 0, 0, 1)));
        plan_add(typed_row(req_row(REQ_ADD_NODE, 0, 0, 0, 0), mk(ST_DONE, 2, 0, 0, 0, 1)));
        plan_add(typed_row(req_row(REQ_ADD_NODE, 0, 0, 0, 0), mk(ST_DONE, 3, 0, 0, 0, 1)));
        plan_add(typed_row(req_row(REQ_ADD_LINK, 4, 5, 0, 0), mk(ST_DONE, 0, 1, 0, 0, 1)));
        plan_add(typed_row(req_row(REQ_ADD_LINK, 4, 5, 0, 0), mk(ST_REJECT, 0, 0, 0, 0, 1)));
        plan_add(typed_row(req_row(REQ_ADD_LINK, 7, 6, 0, 0), mk(ST_DONE, 0, 2, 0, 0, 1)));
        plan_add(typed_row(req_row(REQ_ADD_LINK, 8, 3, 0, 0), mk(ST_REJECT, 0, 0, 0, 0, 1)));
        plan_add(typed_row(req_row(REQ_ADD_LINK, 4, 3, 0, 0), mk(ST_REJECT, 0, 0, 0, 0, 1)));
        plan_add(typed_row(req_row(REQ_ADD_LINK, 4, 6, 0, 0), mk(ST_REJECT, 0, 0, 0, 0, 1)));
        plan_add(typed_row(req_row(REQ_ADD_LINK, 3, 5, 0, 0), mk(ST_REJECT, 0, 0, 0, 0, 1)));
        plan_add(typed_row(req_row(REQ_ADD_LINK, 262143, 131072, 0, 0),
                           mk(ST_REJECT, 0, 0, 0, 0, 1)));
        plan_add(req_row(REQ_ARRANGE, 262143, 262143, 65535, 65535));
        plan_add(typed_row(req_row(REQ_REMOVE_LINK, 0, 0, 0, 65535),
                           mk(ST_DONE, 0, 0, 0, 0, 1)));
        plan_add(typed_row(req_row(REQ_REMOVE_LINK, 0, 0, 0, 1), mk(ST_DONE, 0, 0, 0, 0, 1)));
        plan_add(typed_row(req_row(REQ_REMOVE_NODE, 0, 0, 65535, 0),
                           mk(ST_DONE, 0, 0, 0, 0, 1)));
        plan_add(typed_row(req_row(REQ_REMOVE_NODE, 0, 0, 2, 0), mk(ST_DONE, 0, 0, 0, 0, 1)));
        plan_add(req_row(REQ_ARRANGE, 0, 0, 0, 0));
        plan_add(req_row(6, 0, 0, 0, 0));
        plan_add(req_row(7, 262143, 262143, 65535, 65535));
        plan_add(typed_row(req_row(REQ_CLEAR, 0, 0, 0, 0), mk(ST_DONE, 0, 0, 0, 0, 1)));
        foreach (plan[i])
            offer_item(plan[i]);

        // Build a full table and a long chain so levels saturate and add node overflows.
        for (int i = 0; i < 17; i++)
            offer_item(req_row(REQ_ADD_NODE, 0, 0, 0, 0));
        for (int i = 1; i < 16; i++)
            offer_item(req_row(REQ_ADD_LINK, pin_of(i, 1), pin_of(i + 1, 0), 0, 0));
        offer_item(req_row(REQ_ADD_LINK, pin_of(16, 1), pin_of(1, 0), 0, 0));

        // Long receiver stall during a wide arrange, while requests keep coming.
        fork
            begin
                hold_off = 1;
                repeat (3000) @(posedge clk);
                hold_off = 0;
            end
            begin
                offer_item(req_row(REQ_ARRANGE, 0, 0, 0, 0));
                offer_item(req_row(REQ_ADD_NODE, 0, 0, 0, 0));
                offer_item(req_row(REQ_ARRANGE, 0, 0, 0, 0));
            end
        join
        offer_item(req_row(REQ_CLEAR, 0, 0, 0, 0));

        n = 0;
        while (n < 150) begin
            request_row_t r;
            if (n > 120)
                calm = 1;
            r = random_request();
            offer_item(r);
            if (r.req <= REQ_CLEAR)
                n++;
        end
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2000) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule

/* filelist.f */
hw/rtl/dltcc_pkg.sv
hw/rtl/dag_link_table_cycle_check.sv
test/tb_top.sv
